// File: src/voxel_face_cull_mesher_unit_macros.svh
// assertion macros used by the voxel face cull mesher datapath
// no dependencies; include guarded, empty bodies when SYNTHESIS is defined
`ifndef VOXEL_FACE_CULL_MESHER_UNIT_MACROS_SVH
`define VOXEL_FACE_CULL_MESHER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define VFCM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vfcm assertion failed");
// antecedent implies consequent in the next cycle
`define VFCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vfcm assertion failed");
`else
`define VFCM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define VFCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/vfcm_pkg.sv
// package of the voxel face cull mesher: sizes, payload structs, codes, corner table
// no dependencies
package vfcm_pkg;

    localparam int WORLD_SIDE_LOG2  = 4;
    localparam int SECTOR_SIDE_LOG2 = 2;
    localparam int HEIGHT_LOG2      = 7;
    localparam int ADDR_W           = 2 * WORLD_SIDE_LOG2 + HEIGHT_LOG2;
    localparam int CELL_COUNT       = 1 << ADDR_W;

    localparam int VX_W   = 6;
    localparam int VZ_W   = 8;
    localparam int TYPE_W = 3;
    localparam int FT_W   = 8;

    typedef logic [WORLD_SIDE_LOG2-1:0] t_wcoord;
    typedef logic [HEIGHT_LOG2-1:0]     t_zcoord;
    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [TYPE_W-1:0]          t_block;
    typedef logic [VX_W-1:0]            t_vxy;
    typedef logic [VZ_W-1:0]            t_vz;
    typedef logic [FT_W-1:0]            t_ftype;
    typedef logic [2:0]                 t_face;
    typedef logic [2:0]                 t_vert;
    typedef logic [2:0]                 t_rdidx;
    typedef logic [5:0]                 t_mask;

    // face directions, also the neighbour order
    localparam t_face FACE_EAST  = 3'd0;
    localparam t_face FACE_WEST  = 3'd1;
    localparam t_face FACE_NORTH = 3'd2;
    localparam t_face FACE_SOUTH = 3'd3;
    localparam t_face FACE_UP    = 3'd4;
    localparam t_face FACE_DOWN  = 3'd5;

    localparam t_vert VERT_LAST  = 3'd5;
    localparam t_rdidx RD_CENTER = 3'd0;
    localparam t_rdidx RD_LAST   = 3'd6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_MESH  = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [3:0] world_x;
        logic [3:0] world_y;
        logic [6:0] height;
        logic [2:0] cell_kind;
    } t_in_item;

    typedef struct packed {
        logic [19:0] vertex_word;
        logic [10:0] face_word;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SETTLE,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear;   // write zero at sweep address
        logic load;    // take the input transaction
        logic lookup;  // issue one grid read
        logic decide;  // pick first exposed face
        logic emit;    // produce one vertex
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic rd_last;
        logic solid;
        logic any_face;
        logic out_free;
        logic emit_last;
    } t_stat;

    // corner offsets {z, y, x} per face and vertex
    function automatic logic [2:0] corner(input t_face f, input t_vert v);
        logic [17:0] row;
        row = 18'd0;
        unique case (f)
            FACE_EAST:  row = {3'b101, 3'b111, 3'b001, 3'b111, 3'b011, 3'b001};
            FACE_WEST:  row = {3'b110, 3'b100, 3'b010, 3'b100, 3'b000, 3'b010};
            FACE_NORTH: row = {3'b111, 3'b110, 3'b011, 3'b110, 3'b010, 3'b011};
            FACE_SOUTH: row = {3'b100, 3'b101, 3'b000, 3'b101, 3'b001, 3'b000};
            FACE_UP:    row = {3'b110, 3'b111, 3'b100, 3'b111, 3'b101, 3'b100};
            FACE_DOWN:  row = {3'b000, 3'b001, 3'b010, 3'b001, 3'b011, 3'b010};
            default:    row = 18'd0;
        endcase
        return row[3*v +: 3];
    endfunction

endpackage

// File: src/voxel_face_cull_mesher_unit.sv
// top level of the voxel face cull mesher
// depends on vfcm_pkg, vfcm_ctrl and vfcm_datapath
//
// usage
//  - input channel i_valid / o_ready carries i_item: a write transaction
//    (operation 0) stores cell_kind at the cell, a mesh transaction
//    (operation 1) emits the exposed faces of the cell
//  - output channel o_valid / i_ready carries o_item, one vertex per
//    transaction, six per exposed face in east, west, north, south, up,
//    down order; last marks the final vertex of the cell
//  - a write is stored while idle; a mesh makes seven grid reads
//    (center and six neighbours through the one read port of the cell
//    memory), lets the last read land, makes a decision, then emits
//    the vertices, up to 36; the next transaction is taken after
//  - an empty or fully enclosed cell gives nothing and returns to idle
//    after the decision
//  - after reset a clearing sweep zeroes all 32768 cells, one per cycle;
//    o_ready stays low until it finishes
//  - a stalled receiver holds the output register; vertex generation
//    pauses until it frees, nothing is dropped
module voxel_face_cull_mesher_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  vfcm_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output vfcm_pkg::t_out_item o_item
);

    // command and status between controller and datapath
    vfcm_pkg::t_cmd  cmd;
    vfcm_pkg::t_stat stat;

    vfcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_item.operation),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    // cell memory, neighbour lookup and vertex output register
    vfcm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_out_ready (i_ready),
        .o_stat      (stat),
        .o_item      (o_item),
        .o_out_valid (o_valid)
    );

endmodule

// File: src/vfcm_ctrl.sv
// controller state machine of the voxel face cull mesher
// depends on vfcm_pkg
module vfcm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_op,
    input  vfcm_pkg::t_stat i_stat,
    output vfcm_pkg::t_cmd  o_cmd,
    output logic            o_ready
);

    vfcm_pkg::t_state r_state;
    vfcm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vfcm_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vfcm_pkg::ST_CLEAR: begin
                if (i_stat.clear_done) n_state = vfcm_pkg::ST_IDLE;
            end
            vfcm_pkg::ST_IDLE: begin
                if (i_valid && i_op == vfcm_pkg::OP_MESH) n_state = vfcm_pkg::ST_LOOKUP;
            end
            vfcm_pkg::ST_LOOKUP: begin
                if (i_stat.rd_last) n_state = vfcm_pkg::ST_SETTLE;
            end
            vfcm_pkg::ST_SETTLE: begin
                n_state = vfcm_pkg::ST_DECIDE;
            end
            vfcm_pkg::ST_DECIDE: begin
                n_state = (i_stat.solid && i_stat.any_face) ? vfcm_pkg::ST_EMIT
                                                            : vfcm_pkg::ST_IDLE;
            end
            vfcm_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) n_state = vfcm_pkg::ST_IDLE;
            end
            default: n_state = vfcm_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            vfcm_pkg::ST_CLEAR:  o_cmd.clear = 1'b1;
            vfcm_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            vfcm_pkg::ST_LOOKUP: o_cmd.lookup = 1'b1;
            vfcm_pkg::ST_SETTLE: o_cmd        = '0;
            vfcm_pkg::ST_DECIDE: o_cmd.decide = 1'b1;
            vfcm_pkg::ST_EMIT:   o_cmd.emit   = i_stat.out_free;
            default:             o_cmd        = '0;
        endcase
    end

endmodule

// File: src/vfcm_datapath.sv
// datapath of the voxel face cull mesher: cell memory, neighbour lookup, vertex output register
// depends on vfcm_pkg and voxel_face_cull_mesher_unit_macros.svh
`include "voxel_face_cull_mesher_unit_macros.svh"

module vfcm_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vfcm_pkg::t_cmd      i_cmd,
    input  vfcm_pkg::t_in_item  i_item,
    input  logic                i_out_ready,
    output vfcm_pkg::t_stat     o_stat,
    output vfcm_pkg::t_out_item o_item,
    output logic                o_out_valid
);

    logic [vfcm_pkg::TYPE_W-1:0] r_mem [vfcm_pkg::CELL_COUNT];
    logic [vfcm_pkg::TYPE_W-1:0] r_mem_q;

    vfcm_pkg::t_addr   r_clr_addr;
    vfcm_pkg::t_wcoord r_x;
    vfcm_pkg::t_wcoord r_y;
    vfcm_pkg::t_zcoord r_z;
    vfcm_pkg::t_rdidx  r_rd_idx;
    vfcm_pkg::t_rdidx  r_cap_idx;
    logic              r_cap_vld;
    logic              r_cap_out;
    vfcm_pkg::t_block  r_type;
    vfcm_pkg::t_mask   r_mask;
    vfcm_pkg::t_face   r_face;
    vfcm_pkg::t_vert   r_vert;
    vfcm_pkg::t_out_item r_out;
    logic              r_out_vld;

    vfcm_pkg::t_wcoord nx, ny;
    vfcm_pkg::t_zcoord nz;
    vfcm_pkg::t_face   nb_face;
    logic              outside;
    vfcm_pkg::t_addr   rd_addr;
    vfcm_pkg::t_addr   wr_addr;
    logic              wr_en;
    vfcm_pkg::t_block  wr_data;
    vfcm_pkg::t_face   first_face;
    vfcm_pkg::t_face   next_face;
    logic              no_more;
    logic              vert_last;
    logic [2:0]        cnr;
    vfcm_pkg::t_vxy    vx, vy;
    vfcm_pkg::t_vz     vz;

    // neighbour address for the current read index, edge of grid flagged
    assign nb_face = r_rd_idx - 3'd1;
    always_comb begin
        nx      = r_x;
        ny      = r_y;
        nz      = r_z;
        outside = 1'b0;
        if (r_rd_idx != vfcm_pkg::RD_CENTER) begin
            unique case (nb_face)
                vfcm_pkg::FACE_EAST: begin
                    nx = r_x + vfcm_pkg::t_wcoord'(1);
                    outside = &r_x;
                end
                vfcm_pkg::FACE_WEST: begin
                    nx = r_x - vfcm_pkg::t_wcoord'(1);
                    outside = ~|r_x;
                end
                vfcm_pkg::FACE_NORTH: begin
                    ny = r_y + vfcm_pkg::t_wcoord'(1);
                    outside = &r_y;
                end
                vfcm_pkg::FACE_SOUTH: begin
                    ny = r_y - vfcm_pkg::t_wcoord'(1);
                    outside = ~|r_y;
                end
                vfcm_pkg::FACE_UP: begin
                    nz = r_z + vfcm_pkg::t_zcoord'(1);
                    outside = &r_z;
                end
                vfcm_pkg::FACE_DOWN: begin
                    nz = r_z - vfcm_pkg::t_zcoord'(1);
                    outside = ~|r_z;
                end
                default: outside = 1'b1;
            endcase
        end
    end
    assign rd_addr = {nz, ny, nx};

    // single write port: clearing sweep or write transaction
    assign wr_en   = i_cmd.clear || (i_cmd.load && i_item.operation == vfcm_pkg::OP_WRITE);
    assign wr_addr = i_cmd.clear ? r_clr_addr
                   : {i_item.height[vfcm_pkg::HEIGHT_LOG2-1:0],
                      i_item.world_y[vfcm_pkg::WORLD_SIDE_LOG2-1:0],
                      i_item.world_x[vfcm_pkg::WORLD_SIDE_LOG2-1:0]};
    assign wr_data = i_cmd.clear ? '0 : i_item.cell_kind;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + vfcm_pkg::t_addr'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_item.world_x[vfcm_pkg::WORLD_SIDE_LOG2-1:0];
            r_y <= i_item.world_y[vfcm_pkg::WORLD_SIDE_LOG2-1:0];
            r_z <= i_item.height[vfcm_pkg::HEIGHT_LOG2-1:0];
        end
    end

    // read sequencing: center then six neighbours, data lands in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= vfcm_pkg::RD_CENTER;
            r_cap_vld <= 1'b0;
        end else begin
            r_cap_vld <= i_cmd.lookup;
            if (i_cmd.load) begin
                r_rd_idx <= vfcm_pkg::RD_CENTER;
            end else if (i_cmd.lookup) begin
                r_rd_idx <= r_rd_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_cap_idx <= r_rd_idx;
            r_cap_out <= outside;
        end
        if (r_cap_vld) begin
            if (r_cap_idx == vfcm_pkg::RD_CENTER) begin
                r_type <= r_mem_q;
            end else begin
                r_mask[r_cap_idx - 3'd1] <= r_cap_out || (r_mem_q == '0);
            end
        end
    end

    // face walk over the exposure mask
    always_comb begin
        first_face = vfcm_pkg::FACE_EAST;
        next_face  = vfcm_pkg::FACE_EAST;
        no_more    = 1'b1;
        for (int i = 5; i >= 0; i--) begin
            if (r_mask[i]) first_face = 3'(i);
            if (r_mask[i] && 3'(i) > r_face) begin
                next_face = 3'(i);
                no_more   = 1'b0;
            end
        end
    end
    assign vert_last = (r_vert == vfcm_pkg::VERT_LAST) && no_more;

    assign cnr = vfcm_pkg::corner(r_face, r_vert);
    assign vx  = vfcm_pkg::t_vxy'(r_x[vfcm_pkg::SECTOR_SIDE_LOG2-1:0]) + vfcm_pkg::t_vxy'(cnr[0]);
    assign vy  = vfcm_pkg::t_vxy'(r_y[vfcm_pkg::SECTOR_SIDE_LOG2-1:0]) + vfcm_pkg::t_vxy'(cnr[1]);
    assign vz  = vfcm_pkg::t_vz'(r_z) + vfcm_pkg::t_vz'(cnr[2]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_face <= first_face;
            r_vert <= '0;
        end else if (i_cmd.emit) begin
            if (r_vert == vfcm_pkg::VERT_LAST) begin
                r_vert <= '0;
                r_face <= next_face;
            end else begin
                r_vert <= r_vert + 3'd1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.vertex_word <= {vz, vy, vx};
            r_out.face_word   <= {r_face, vfcm_pkg::t_ftype'(r_type)};
            r_out.last        <= vert_last;
        end
    end

    assign o_item      = r_out;
    assign o_out_valid = r_out_vld;

    assign o_stat.clear_done = &r_clr_addr;
    assign o_stat.rd_last    = (r_rd_idx == vfcm_pkg::RD_LAST);
    assign o_stat.solid      = (r_type != '0);
    assign o_stat.any_face   = |r_mask;
    assign o_stat.out_free   = !r_out_vld || i_out_ready;
    assign o_stat.emit_last  = vert_last;

    `VFCM_ASSERT_NOW(a_emit_exposed, i_clk, i_rst_n, i_cmd.emit, r_mask[r_face])
    `VFCM_ASSERT_NOW(a_emit_solid, i_clk, i_rst_n, i_cmd.emit, r_type != '0)
    `VFCM_ASSERT_NOW(a_emit_room, i_clk, i_rst_n, i_cmd.emit, !r_out_vld || i_out_ready)
    `VFCM_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, i_cmd.emit && vert_last, !i_cmd.emit)

endmodule
